/* design/sky_cubemap_texel_generator_assert.svh */
// Assertion macros used by the sky cube-map texel generator top level.
// Needs nothing else; the top level includes it by file name.
`ifndef SKY_CUBEMAP_TEXEL_GENERATOR_ASSERT_SVH
`define SKY_CUBEMAP_TEXEL_GENERATOR_ASSERT_SVH

// The expression holds at every rising clock edge outside reset.
`define SKY_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sky cube-map assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SKY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sky cube-map assertion failed");

`endif

/* design/skycube_pkg.sv */
// Types and constants of the sky cube-map texel generator.
// Depends on nothing; skycube_shade and the top level use it by scoped names.
package skycube_pkg;

    localparam int Q_FRAC = 14;
    localparam int Q_HALF = 8192;
    localparam logic signed [15:0] Q_ONE = 16'sd16384;

    localparam int CFG_EDGE_W = 12;
    localparam logic [CFG_EDGE_W-1:0] EDGE_RESET = 12'd256;
    localparam logic REG_FACE_EDGE = 1'b0;

    localparam int DIV_Q_W = 15;
    localparam int ROOT_W = 15;
    localparam int LEN2_W = 30;

    typedef logic signed [15:0] t_q14;
    typedef logic [2:0][15:0] t_vec3;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    localparam t_q14 ZENITH_Q [3] = '{16'sd1638, 16'sd5243, 16'sd11796};
    localparam t_q14 MID_Q [3] = '{16'sd6881, 16'sd10158, 16'sd14418};
    localparam t_q14 HORIZON_Q [3] = '{16'sd11141, 16'sd13435, 16'sd15565};
    localparam t_q14 NADIR_Q [3] = '{16'sd4096, 16'sd4588, 16'sd5734};
    localparam t_q14 SUN_DIR_Q [3] = '{-16'sd5862, 16'sd14654, -16'sd4396};
    localparam int SUN_TINT_Q [3] = '{16384, 15565, 12288};
    localparam int GLOW_Q = 5734;
    localparam int SUN_GAIN = 3;

endpackage

/* design/skycube_div.sv */
// Pipelined restoring divider, one quotient bit per stage, truncating sign.
// Uses no package; instantiated by the sky cube-map texel generator top level.
module skycube_div #(
    parameter int NUM_W  = 25,
    parameter int DEN_W  = 11,
    parameter int Q_W    = 15,
    parameter int SIDE_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_neg,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [DEN_W-1:0]    i_den,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output logic signed [Q_W:0] o_quo,
    output logic [SIDE_W-1:0]   o_side
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W:0]        r_vld;
    logic [NUM_W-1:0]    r_rem  [Q_W];
    logic [DEN_W-1:0]    r_den  [Q_W];
    logic [Q_W-1:0]      r_quo  [Q_W+1];
    logic                r_neg  [Q_W+1];
    logic [SIDE_W-1:0]   r_side [Q_W+1];
    logic [NUM_W-1:0]    n_rem  [Q_W];
    logic [Q_W-1:0]      n_quo  [Q_W];
    logic signed [Q_W:0] w_mag;

    always_comb begin
        for (int s = 0; s < Q_W; s++) begin
            n_rem[s] = r_rem[s];
            n_quo[s] = r_quo[s];
            if (W'(r_rem[s]) >= (W'(r_den[s]) << (Q_W - 1 - s))) begin
                n_rem[s] = NUM_W'(W'(r_rem[s]) - (W'(r_den[s]) << (Q_W - 1 - s)));
                n_quo[s][Q_W - 1 - s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_neg[0]  <= i_neg;
            r_side[0] <= i_side;
            for (int s = 0; s < Q_W; s++) begin
                r_quo[s+1]  <= n_quo[s];
                r_neg[s+1]  <= r_neg[s];
                r_side[s+1] <= r_side[s];
            end
            for (int s = 0; s < Q_W - 1; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_den[s+1] <= r_den[s];
            end
        end
    end

    assign w_mag   = {1'b0, r_quo[Q_W]};
    assign o_quo   = r_neg[Q_W] ? -w_mag : w_mag;
    assign o_valid = r_vld[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

/* design/skycube_sqrt.sv */
// Pipelined integer square root, one result bit per stage, no multipliers.
// Uses no package; instantiated by the sky cube-map texel generator top level.
module skycube_sqrt #(
    parameter int V_W    = 30,
    parameter int R_W    = 15,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [V_W-1:0]    i_value,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [R_W-1:0]    o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CW = (V_W > 2 * R_W + 1) ? V_W : 2 * R_W + 1;

    logic [R_W:0]        r_vld;
    logic [V_W-1:0]      r_v    [R_W];
    logic [CW-1:0]       r_sq   [R_W];
    logic [R_W-1:0]      r_root [R_W+1];
    logic [SIDE_W-1:0]   r_side [R_W+1];
    logic [CW-1:0]       n_sq   [R_W];
    logic [R_W-1:0]      n_root [R_W];
    logic [CW-1:0]       w_cand [R_W];

    always_comb begin
        for (int s = 0; s < R_W; s++) begin
            w_cand[s] = r_sq[s] + (CW'(r_root[s]) << (R_W - s))
                      + (CW'(1) << (2 * (R_W - 1 - s)));
            n_sq[s]   = r_sq[s];
            n_root[s] = r_root[s];
            if (w_cand[s] <= CW'(r_v[s])) begin
                n_sq[s] = w_cand[s];
                n_root[s][R_W - 1 - s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[R_W-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]    <= i_value;
            r_sq[0]   <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int s = 0; s < R_W; s++) begin
                r_root[s+1] <= n_root[s];
                r_side[s+1] <= r_side[s];
            end
            for (int s = 0; s < R_W - 1; s++) begin
                r_v[s+1]  <= r_v[s];
                r_sq[s+1] <= n_sq[s];
            end
        end
    end

    assign o_valid = r_vld[R_W];
    assign o_root  = r_root[R_W];
    assign o_side  = r_side[R_W];

endmodule

/* design/skycube_shade.sv */
// Shading pipeline: sky gradient, sun highlight by repeated squaring, RGB out.
// Depends on skycube_pkg; instantiated by the sky cube-map texel generator.
module skycube_shade (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_bad,
    input  skycube_pkg::t_vec3 i_norm,
    output logic               o_valid,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    localparam int LAT = 14;
    localparam int NSQ = 8;

    logic [LAT-1:0] r_vld;

    logic signed [31:0] r_a_prod [3];
    logic [14:0]        r_a_f;
    logic signed [15:0] r_a_base [3];
    logic signed [15:0] r_a_diff [3];
    logic               r_a_bad;

    logic [14:0]        r_b_p;
    logic signed [31:0] r_b_gp [3];
    logic signed [15:0] r_b_base [3];
    logic               r_b_bad;

    logic [14:0]        r_sq  [1:NSQ];
    logic signed [15:0] r_col [1:NSQ][3];
    logic               r_bad [1:NSQ];
    logic [14:0]        r_p16 [5:NSQ];

    logic [15:0]        r_d_inten;
    logic signed [15:0] r_d_col [3];
    logic               r_d_bad;

    logic [16:0]        r_e_tint [3];
    logic signed [15:0] r_e_col [3];
    logic               r_e_bad;

    logic [14:0]        r_f_cl [3];
    logic               r_f_bad;

    logic [7:0]         r_g_rgb [3];

    logic signed [15:0] w_t;
    logic signed [31:0] n_prod [3];
    logic [14:0]        n_f;
    logic signed [15:0] n_base [3];
    logic signed [15:0] n_diff [3];
    logic signed [31:0] w_sum;
    logic signed [31:0] w_dot;
    logic [14:0]        n_p;
    logic [29:0]        w_pp [0:NSQ-1];
    logic [14:0]        w_sq_in [0:NSQ-1];
    logic [14:0]        n_sq [1:NSQ];
    logic [15:0]        n_inten;
    logic [16:0]        n_tint [3];
    logic [14:0]        n_cl [3];
    logic [7:0]         n_rgb [3];
    int                 w_c [3];

    always_comb begin
        w_t = $signed(i_norm[1]);
        for (int i = 0; i < 3; i++) begin
            n_prod[i] = $signed(i_norm[i]) * skycube_pkg::SUN_DIR_Q[i];
        end
        priority if (int'(w_t) >= skycube_pkg::Q_HALF) begin
            n_f = 15'(2 * (int'(w_t) - skycube_pkg::Q_HALF));
            for (int i = 0; i < 3; i++) begin
                n_base[i] = skycube_pkg::MID_Q[i];
                n_diff[i] = 16'(skycube_pkg::ZENITH_Q[i] - skycube_pkg::MID_Q[i]);
            end
        end else if (w_t >= 16'sd0) begin
            n_f = 15'(2 * int'(w_t));
            for (int i = 0; i < 3; i++) begin
                n_base[i] = skycube_pkg::HORIZON_Q[i];
                n_diff[i] = 16'(skycube_pkg::MID_Q[i] - skycube_pkg::HORIZON_Q[i]);
            end
        end else begin
            n_f = 15'(-int'(w_t));
            for (int i = 0; i < 3; i++) begin
                n_base[i] = skycube_pkg::HORIZON_Q[i];
                n_diff[i] = 16'(skycube_pkg::NADIR_Q[i] - skycube_pkg::HORIZON_Q[i]);
            end
        end
    end

    always_comb begin
        w_sum = r_a_prod[0] + r_a_prod[1] + r_a_prod[2];
        w_dot = w_sum >>> skycube_pkg::Q_FRAC;
        priority if (w_dot < 32'sd0) begin
            n_p = '0;
        end else if (w_dot > 32'sd16384) begin
            n_p = 15'(skycube_pkg::Q_ONE);
        end else begin
            n_p = 15'(w_dot);
        end
    end

    always_comb begin
        w_sq_in[0] = r_b_p;
        for (int j = 1; j < NSQ; j++) begin
            w_sq_in[j] = r_sq[j];
        end
        for (int j = 0; j < NSQ; j++) begin
            w_pp[j]   = 30'(w_sq_in[j]) * 30'(w_sq_in[j]);
            n_sq[j+1] = 15'(w_pp[j] >> skycube_pkg::Q_FRAC);
        end
        n_inten = 16'(skycube_pkg::SUN_GAIN * int'(r_sq[NSQ])
                + ((int'(r_p16[NSQ]) * skycube_pkg::GLOW_Q) >>> skycube_pkg::Q_FRAC));
        for (int i = 0; i < 3; i++) begin
            n_tint[i] = 17'((int'(r_d_inten) * skycube_pkg::SUN_TINT_Q[i])
                      >>> skycube_pkg::Q_FRAC);
            w_c[i] = int'(r_e_col[i]) + int'(r_e_tint[i]);
            priority if (w_c[i] < 0) begin
                n_cl[i] = '0;
            end else if (w_c[i] > int'(skycube_pkg::Q_ONE)) begin
                n_cl[i] = 15'(skycube_pkg::Q_ONE);
            end else begin
                n_cl[i] = 15'(w_c[i]);
            end
            n_rgb[i] = r_f_bad ? 8'd0
                     : 8'((int'(r_f_cl[i]) * 255) >>> skycube_pkg::Q_FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_f   <= n_f;
            r_a_bad <= i_bad;
            r_b_p   <= n_p;
            r_b_bad <= r_a_bad;
            r_bad[1] <= r_b_bad;
            r_d_inten <= n_inten;
            r_d_bad <= r_bad[NSQ];
            r_e_bad <= r_d_bad;
            r_f_bad <= r_e_bad;
            r_p16[5] <= r_sq[4];
            for (int j = 6; j <= NSQ; j++) begin
                r_p16[j] <= r_p16[j-1];
            end
            for (int j = 1; j <= NSQ; j++) begin
                r_sq[j] <= n_sq[j];
            end
            for (int j = 2; j <= NSQ; j++) begin
                r_bad[j] <= r_bad[j-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_a_prod[i] <= n_prod[i];
                r_a_base[i] <= n_base[i];
                r_a_diff[i] <= n_diff[i];
                r_b_gp[i]   <= r_a_diff[i] * $signed({1'b0, r_a_f});
                r_b_base[i] <= r_a_base[i];
                r_col[1][i] <= 16'(r_b_base[i] + (r_b_gp[i] >>> skycube_pkg::Q_FRAC));
                for (int j = 2; j <= NSQ; j++) begin
                    r_col[j][i] <= r_col[j-1][i];
                end
                r_d_col[i]  <= r_col[NSQ][i];
                r_e_tint[i] <= n_tint[i];
                r_e_col[i]  <= r_d_col[i];
                r_f_cl[i]   <= n_cl[i];
                r_g_rgb[i]  <= n_rgb[i];
            end
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_red   = r_g_rgb[0];
    assign o_green = r_g_rgb[1];
    assign o_blue  = r_g_rgb[2];

endmodule

/* design/sky_cubemap_texel_generator.sv */
// Sky cube-map texel generator top level; uses skycube_pkg, skycube_div,
// skycube_sqrt, skycube_shade and the assertion macro header. Each accepted
// item (face, x, y) yields one RGB result. The block accepts one item per
// clock cycle unless stalled. An accepted item passes through the input
// register, the u/v dividers (16 stages), the direction and square registers
// (2 stages), the length square root (16 stages), the normalizing dividers
// (16 stages) and the shading pipeline (14 stages) to the output register.
// One skid entry sits behind the output register, and the whole pipeline
// stalls only while that entry holds a result. The user must write face edge
// through the APB port only while the block is idle; the block does not enforce it.
`include "sky_cubemap_texel_generator_assert.svh"

module sky_cubemap_texel_generator #(
    parameter int MAX_EDGE = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_face_index,
    input  logic [10:0] i_texel_x,
    input  logic [10:0] i_texel_y,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    localparam int D_W = (MAX_EDGE > 2) ? $clog2(MAX_EDGE) : 1;
    localparam int U_NUM_W = D_W + skycube_pkg::Q_FRAC;
    localparam int N_NUM_W = 15 + skycube_pkg::Q_FRAC;
    localparam int SIDE_W = 49;

    logic [skycube_pkg::CFG_EDGE_W-1:0] r_face_edge;
    logic [D_W-1:0] r_dm1;
    logic [D_W-1:0] n_dm1;
    logic           w_en;

    logic           r_t0_vld;
    logic [2:0]     r_t0_face;
    logic [D_W-1:0] r_t0_x;
    logic [D_W-1:0] r_t0_y;

    logic signed [D_W+1:0] w_sx;
    logic signed [D_W+1:0] w_sy;
    logic [D_W-1:0]        w_xmag;
    logic [D_W-1:0]        w_ymag;
    logic                  w_bad;

    logic                  w_u_vld;
    logic                  w_v_vld;
    logic signed [15:0]    w_u;
    logic signed [15:0]    w_v;
    logic [2:0]            w_u_face;
    logic                  w_v_bad;

    logic                  r_t1_vld;
    logic                  r_t1_bad;
    skycube_pkg::t_vec3    r_t1_dir;
    skycube_pkg::t_vec3    n_dir;

    logic                  r_t2_vld;
    logic                  r_t2_bad;
    skycube_pkg::t_vec3    r_t2_dir;
    logic [28:0]           r_t2_sq [3];
    logic signed [31:0]    w_sq_full [3];
    logic [skycube_pkg::LEN2_W-1:0] w_len2;

    logic                  w_r_vld;
    logic [skycube_pkg::ROOT_W-1:0] w_len;
    logic [SIDE_W-1:0]     w_r_side;
    skycube_pkg::t_vec3    w_r_dir;

    logic [2:0]            w_n_vld;
    logic [2:0]            w_n_bad;
    skycube_pkg::t_vec3    w_norm;

    logic                  w_sh_vld;
    logic [7:0]            w_sh_r;
    logic [7:0]            w_sh_g;
    logic [7:0]            w_sh_b;

    logic                  r_out_vld;
    logic [7:0]            r_out_r;
    logic [7:0]            r_out_g;
    logic [7:0]            r_out_b;
    logic                  r_skid_vld;
    logic [7:0]            r_skid_r;
    logic [7:0]            r_skid_g;
    logic [7:0]            r_skid_b;

    function automatic logic [D_W-1:0] f_dm1(
        logic [skycube_pkg::CFG_EDGE_W-1:0] edge_val
    );
        logic [D_W-1:0] dm1;
        priority if (int'(edge_val) > MAX_EDGE) begin
            dm1 = D_W'(MAX_EDGE - 1);
        end else if (int'(edge_val) < 2) begin
            dm1 = D_W'(1);
        end else begin
            dm1 = D_W'(int'(edge_val) - 1);
        end
        return dm1;
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr[2] == skycube_pkg::REG_FACE_EDGE) ? 32'(r_face_edge) : '0;

    assign n_dm1 = f_dm1(pwdata[skycube_pkg::CFG_EDGE_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_edge <= skycube_pkg::EDGE_RESET;
            r_dm1       <= f_dm1(skycube_pkg::EDGE_RESET);
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[2] == skycube_pkg::REG_FACE_EDGE) begin
                r_face_edge <= pwdata[skycube_pkg::CFG_EDGE_W-1:0];
                r_dm1       <= n_dm1;
            end
        end
    end

    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0_vld <= 1'b0;
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
        end else if (w_en) begin
            r_t0_vld <= i_valid;
            r_t1_vld <= w_u_vld;
            r_t2_vld <= r_t1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0_face <= i_face_index;
            r_t0_x <= (int'(i_texel_x) > int'(r_dm1)) ? r_dm1 : D_W'(i_texel_x);
            r_t0_y <= (int'(i_texel_y) > int'(r_dm1)) ? r_dm1 : D_W'(i_texel_y);
        end
    end

    assign w_sx   = $signed({1'b0, r_t0_x, 1'b0}) - $signed({2'b00, r_dm1});
    assign w_sy   = $signed({1'b0, r_t0_y, 1'b0}) - $signed({2'b00, r_dm1});
    assign w_xmag = D_W'(w_sx[D_W+1] ? -w_sx : w_sx);
    assign w_ymag = D_W'(w_sy[D_W+1] ? -w_sy : w_sy);
    assign w_bad  = r_t0_face > 3'(skycube_pkg::FACE_NEG_Z);

    skycube_div #(
        .NUM_W(U_NUM_W), .DEN_W(D_W), .Q_W(skycube_pkg::DIV_Q_W), .SIDE_W(3)
    ) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_t0_vld),
        .i_neg(w_sx[D_W+1]), .i_num({w_xmag, {skycube_pkg::Q_FRAC{1'b0}}}),
        .i_den(r_dm1), .i_side(r_t0_face),
        .o_valid(w_u_vld), .o_quo(w_u), .o_side(w_u_face)
    );

    skycube_div #(
        .NUM_W(U_NUM_W), .DEN_W(D_W), .Q_W(skycube_pkg::DIV_Q_W), .SIDE_W(1)
    ) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_t0_vld),
        .i_neg(w_sy[D_W+1]), .i_num({w_ymag, {skycube_pkg::Q_FRAC{1'b0}}}),
        .i_den(r_dm1), .i_side(w_bad),
        .o_valid(w_v_vld), .o_quo(w_v), .o_side(w_v_bad)
    );

    always_comb begin
        unique case (skycube_pkg::t_face'(w_u_face))
            skycube_pkg::FACE_POS_X: begin
                n_dir[0] = skycube_pkg::Q_ONE; n_dir[1] = -w_v; n_dir[2] = -w_u;
            end
            skycube_pkg::FACE_NEG_X: begin
                n_dir[0] = -skycube_pkg::Q_ONE; n_dir[1] = -w_v; n_dir[2] = w_u;
            end
            skycube_pkg::FACE_POS_Y: begin
                n_dir[0] = w_u; n_dir[1] = skycube_pkg::Q_ONE; n_dir[2] = w_v;
            end
            skycube_pkg::FACE_NEG_Y: begin
                n_dir[0] = w_u; n_dir[1] = -skycube_pkg::Q_ONE; n_dir[2] = -w_v;
            end
            skycube_pkg::FACE_POS_Z: begin
                n_dir[0] = w_u; n_dir[1] = -w_v; n_dir[2] = skycube_pkg::Q_ONE;
            end
            default: begin
                n_dir[0] = -w_u; n_dir[1] = -w_v; n_dir[2] = -skycube_pkg::Q_ONE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sq_full[i] = $signed(r_t1_dir[i]) * $signed(r_t1_dir[i]);
        end
        w_len2 = skycube_pkg::LEN2_W'(r_t2_sq[0]) + skycube_pkg::LEN2_W'(r_t2_sq[1])
               + skycube_pkg::LEN2_W'(r_t2_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_dir <= n_dir;
            r_t1_bad <= w_v_bad;
            r_t2_dir <= r_t1_dir;
            r_t2_bad <= r_t1_bad;
            for (int i = 0; i < 3; i++) begin
                r_t2_sq[i] <= w_sq_full[i][28:0];
            end
        end
    end

    skycube_sqrt #(
        .V_W(skycube_pkg::LEN2_W), .R_W(skycube_pkg::ROOT_W), .SIDE_W(SIDE_W)
    ) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_t2_vld),
        .i_value(w_len2), .i_side({r_t2_bad, r_t2_dir}),
        .o_valid(w_r_vld), .o_root(w_len), .o_side(w_r_side)
    );

    assign w_r_dir = w_r_side[47:0];

    for (genvar g = 0; g < 3; g++) begin : g_norm
        logic signed [15:0] w_c;
        logic [14:0]        w_mag;
        logic signed [15:0] w_q;

        assign w_c   = $signed(w_r_dir[g]);
        assign w_mag = 15'(w_c[15] ? -w_c : w_c);
        assign w_norm[g] = w_q;

        skycube_div #(
            .NUM_W(N_NUM_W), .DEN_W(skycube_pkg::ROOT_W),
            .Q_W(skycube_pkg::DIV_Q_W), .SIDE_W(1)
        ) u_div_n (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_r_vld),
            .i_neg(w_c[15]), .i_num({w_mag, {skycube_pkg::Q_FRAC{1'b0}}}),
            .i_den(w_len), .i_side(w_r_side[SIDE_W-1]),
            .o_valid(w_n_vld[g]), .o_quo(w_q), .o_side(w_n_bad[g])
        );
    end

    skycube_shade u_shade (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_n_vld[0]),
        .i_bad(w_n_bad[0]), .i_norm(w_norm),
        .o_valid(w_sh_vld), .o_red(w_sh_r), .o_green(w_sh_g), .o_blue(w_sh_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_sh_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out_r <= r_skid_r;
                r_out_g <= r_skid_g;
                r_out_b <= r_skid_b;
            end
        end else if (w_sh_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out_r <= w_sh_r;
                r_out_g <= w_sh_g;
                r_out_b <= w_sh_b;
            end else begin
                r_skid_r <= w_sh_r;
                r_skid_g <= w_sh_g;
                r_skid_b <= w_sh_b;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_red   = r_out_r;
    assign o_green = r_out_g;
    assign o_blue  = r_out_b;

    `SKY_ASSERT_ALWAYS(a_skid_needs_out, i_clk, i_rst_n, !r_skid_vld || r_out_vld)
    `SKY_ASSERT_NEXT(a_stall_holds_input, i_clk, i_rst_n, !w_en, $stable(r_t0_vld))
    `SKY_ASSERT_ALWAYS(a_edge_in_range, i_clk, i_rst_n, (r_dm1 != '0) && (int'(r_dm1) < MAX_EDGE))
    `SKY_ASSERT_ALWAYS(a_lanes_lockstep, i_clk, i_rst_n, (w_u_vld == w_v_vld) && (&w_n_vld || !(|w_n_vld)))
    `SKY_ASSERT_ALWAYS(a_lanes_bad, i_clk, i_rst_n, !w_n_vld[0] || (w_n_bad == {3{w_n_bad[0]}}))

endmodule

/* tb/tb_top.sv */
// Testbench for the sky cube-map texel generator: drives texel requests and
// face-edge writes, predicts each RGB result in fixed point and checks it.
// Depends on skycube_pkg and the sky_cubemap_texel_generator RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 100;
    localparam int EXP_DEPTH = 1024;
    localparam logic [2:0] ADDR_FACE_EDGE = 3'd0;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_face_index;
    logic [10:0] i_texel_x;
    logic [10:0] i_texel_y;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;

    t_rgb        expected_rgb [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    logic [11:0] edge_reg;
    int          error_count;
    int          result_count;
    int          item_count;
    int          cycle_count;
    bit          send_idle_on;
    bit          sink_idle_on;

    sky_cubemap_texel_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready), .i_face_index(i_face_index),
        .i_texel_x(i_texel_x), .i_texel_y(i_texel_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint floor_shift(longint p);
        if (p >= 0) begin
            return p >>> 14;
        end
        return -((-p + 16383) >>> 14);
    endfunction

    function automatic longint div_trunc(longint num, longint den);
        longint mag;
        mag = (num < 0 ? -num : num) / den;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint c;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            c = r | (longint'(1) << b);
            if (c * c <= v) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v < 0) begin
            return 0;
        end
        if (v > 16384) begin
            return 16384;
        end
        return v;
    endfunction

    function automatic t_rgb shade_texel(logic [2:0] face, logic [10:0] tx, logic [10:0] ty);
        t_rgb   rgb;
        longint e, d, x, y, u, v, len, dotp, p, p16, glow, t, c, a, b, f;
        longint dir[3];
        longint n[3];
        e = edge_reg;
        rgb = '0;
        if (face > 5) begin
            return rgb;
        end
        if (e < 2) begin
            e = 2;
        end
        if (e > 2048) begin
            e = 2048;
        end
        d = e - 1;
        x = (tx > d) ? d : tx;
        y = (ty > d) ? d : ty;
        u = div_trunc((2 * x - d) * 16384, d);
        v = div_trunc((2 * y - d) * 16384, d);
        case (skycube_pkg::t_face'(face))
            skycube_pkg::FACE_POS_X: begin
                dir[0] = 16384;  dir[1] = -v;     dir[2] = -u;
            end
            skycube_pkg::FACE_NEG_X: begin
                dir[0] = -16384; dir[1] = -v;     dir[2] = u;
            end
            skycube_pkg::FACE_POS_Y: begin
                dir[0] = u;      dir[1] = 16384;  dir[2] = v;
            end
            skycube_pkg::FACE_NEG_Y: begin
                dir[0] = u;      dir[1] = -16384; dir[2] = -v;
            end
            skycube_pkg::FACE_POS_Z: begin
                dir[0] = u;      dir[1] = -v;     dir[2] = 16384;
            end
            default: begin
                dir[0] = -u;     dir[1] = -v;     dir[2] = -16384;
            end
        endcase
        len = root_floor(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]);
        for (int i = 0; i < 3; i++) begin
            n[i] = div_trunc(dir[i] * 16384, len);
        end
        dotp = floor_shift(n[0] * skycube_pkg::SUN_DIR_Q[0] + n[1] * skycube_pkg::SUN_DIR_Q[1]
                           + n[2] * skycube_pkg::SUN_DIR_Q[2]);
        p = unit_clamp(dotp);
        for (int i = 0; i < 4; i++) begin
            p = (p * p) >>> 14;
        end
        p16 = p;
        for (int i = 0; i < 4; i++) begin
            p = (p * p) >>> 14;
        end
        glow = skycube_pkg::SUN_GAIN * p + ((p16 * skycube_pkg::GLOW_Q) >>> 14);
        t = n[1];
        for (int i = 0; i < 3; i++) begin
            if (t >= 8192) begin
                a = skycube_pkg::MID_Q[i]; b = skycube_pkg::ZENITH_Q[i]; f = (t - 8192) * 2;
            end else if (t >= 0) begin
                a = skycube_pkg::HORIZON_Q[i]; b = skycube_pkg::MID_Q[i]; f = t * 2;
            end else begin
                a = skycube_pkg::HORIZON_Q[i]; b = skycube_pkg::NADIR_Q[i]; f = -t;
            end
            c = a + floor_shift((b - a) * f);
            c = unit_clamp(c + ((glow * skycube_pkg::SUN_TINT_Q[i]) >>> 14));
            c = (c * 255) >>> 14;
            if (i == 0) begin
                rgb.red = c[7:0];
            end else if (i == 1) begin
                rgb.green = c[7:0];
            end else begin
                rgb.blue = c[7:0];
            end
        end
        return rgb;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, result_count);
        error_count++;
    endtask

    task automatic write_face_edge(logic [11:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_FACE_EDGE;
        pwdata <= {20'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        edge_reg = value;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_texel(logic [2:0] face, logic [10:0] tx, logic [10:0] ty);
        while (send_idle_on && $urandom_range(99) < 32) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_face_index <= face;
        i_texel_x <= tx;
        i_texel_y <= ty;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        expected_rgb[exp_wr % EXP_DEPTH] = shade_texel(face, tx, ty);
        exp_wr++;
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (exp_wr != exp_rd) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_directed_faces();
        for (int f = 0; f < 8; f++) begin
            send_texel(f[2:0], 11'd0, 11'd0);
            send_texel(f[2:0], 11'd255, 11'd255);
        end
        send_texel(3'(skycube_pkg::FACE_POS_Y), 11'd128, 11'd128);
        send_texel(3'(skycube_pkg::FACE_POS_X), 11'd2047, 11'd0);
        send_texel(3'(skycube_pkg::FACE_POS_Z), 11'd0, 11'd2047);
        send_texel(3'(skycube_pkg::FACE_NEG_Z), 11'd1365, 11'd682);
        send_texel(3'(skycube_pkg::FACE_NEG_X), 11'd300, 11'd20);
        drain_results();
    endtask

    task automatic test_edge_settings();
        logic [11:0] edges[6] = '{12'd2, 12'd2048, 12'd0, 12'd4095, 12'd1, 12'd3};
        foreach (edges[k]) begin
            write_face_edge(edges[k]);
            for (int i = 0; i < 8; i++) begin
                send_texel(3'($urandom_range(7)), 11'($urandom_range(2047)),
                           11'($urandom_range(2047)));
            end
            send_texel(3'(skycube_pkg::FACE_POS_Y), 11'd2047, 11'd2047);
            drain_results();
        end
    endtask

    task automatic test_random_texels();
        logic [11:0] edge_val;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(3))
                0: edge_val = 12'($urandom_range(2, 16));
                1: edge_val = 12'($urandom_range(2, 2048));
                2: edge_val = 12'd2048;
                default: edge_val = 12'($urandom_range(4095));
            endcase
            write_face_edge(edge_val);
            send_idle_on = (phase != 2);
            sink_idle_on = (phase != 2);
            for (int i = 0; i < 65; i++) begin
                send_texel(3'(($urandom_range(9) == 0) ? $urandom_range(6, 7)
                                                       : $urandom_range(5)),
                           11'($urandom_range(2047)
                               % (($urandom_range(1)) ? 2048 : edge_val + 1)),
                           11'($urandom_range(2047)
                               % (($urandom_range(1)) ? 2048 : edge_val + 1)));
            end
            drain_results();
        end
        send_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_rgb want;
        cycle_count++;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_rgb[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_red !== want.red) report_mismatch("red", o_red, want.red);
                if (o_green !== want.green) report_mismatch("green", o_green, want.green);
                if (o_blue !== want.blue) report_mismatch("blue", o_blue, want.blue);
            end
            result_count++;
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= !(sink_idle_on && $urandom_range(99) < 32);
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_face_index = '0;
        i_texel_x = '0;
        i_texel_y = '0;
        i_ready = 1'b0;
        edge_reg = skycube_pkg::EDGE_RESET;
        exp_wr = 0;
        exp_rd = 0;
        error_count = 0;
        result_count = 0;
        item_count = 0;
        cycle_count = 0;
        send_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_faces();
        test_edge_settings();
        test_random_texels();
        drain_results();
        if (exp_wr != exp_rd) begin
            report_mismatch("results missing", 0, exp_wr - exp_rd);
        end
        $display("Sent %0d texel requests over eight face codes and many edge lengths;", item_count);
        $display("checked %0d RGB results with %0d mismatches.", result_count, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/skycube_pkg.sv
design/skycube_div.sv
design/skycube_sqrt.sv
design/skycube_shade.sv
design/sky_cubemap_texel_generator.sv
tb/tb_top.sv
